/* rtl/keyed_record_table_assert.svh */
// Assertion helpers for the record table; expand inside a module that has clk and arst_n.
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KRT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed_record_table: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define KRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed_record_table: next-cycle check failed");

`endif

/* rtl/krt_pkg.sv */
`timescale 1ns / 1ps

package krt_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int ACT_W  = 2;
	localparam int KEY_W  = 32;
	localparam int PAY_W  = 64;
	localparam int SLOT_W = 6;
	localparam int STAT_W = 3;
	localparam int CMP_W  = 7;
	localparam int OCC_W  = 7;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_FIND   = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_READ   = 2'd3
	} krt_action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_DUP     = 3'd2,
		ST_MISSING = 3'd3,
		ST_RANGE   = 3'd4
	} krt_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_READ,
		S_SHIFT
	} krt_state_t;

	typedef enum logic [2:0] {
		RES_FULL,
		RES_HIT,
		RES_MISS,
		RES_ADD,
		RES_RANGE,
		RES_READ
	} krt_res_t;

	typedef struct packed {
		logic     capture;
		logic     srch_step;
		logic     read_slot;
		logic     shift_init;
		logic     shift_step;
		logic     append;
		logic     dec;
		logic     res_ld;
		krt_res_t res_sel;
		logic     finish;
	} krt_cmd_t;

	typedef struct packed {
		krt_action_t act;
		logic        full;
		logic        empty;
		logic        hit;
		logic        last_miss;
		logic        slot_ok;
		logic        shift_done;
	} krt_sts_t;

endpackage

/* rtl/krt_ctrl.sv */
`timescale 1ns / 1ps

module krt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  krt_pkg::krt_sts_t sts,
	output krt_pkg::krt_cmd_t cmd
);

	krt_pkg::krt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			krt_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = krt_pkg::S_DECODE;
				end
			end
			krt_pkg::S_DECODE: begin
				unique case (sts.act) inside
					krt_pkg::ACT_ADD: begin
						if (sts.full) begin
							cmd.res_ld  = 1'b1;
							cmd.res_sel = krt_pkg::RES_FULL;
							cmd.finish  = 1'b1;
							state_d     = krt_pkg::S_IDLE;
						end else if (sts.empty) begin
							cmd.append  = 1'b1;
							cmd.res_ld  = 1'b1;
							cmd.res_sel = krt_pkg::RES_ADD;
							cmd.finish  = 1'b1;
							state_d     = krt_pkg::S_IDLE;
						end else begin
							state_d = krt_pkg::S_SEARCH;
						end
					end
					krt_pkg::ACT_FIND, krt_pkg::ACT_REMOVE: begin
						if (sts.empty) begin
							cmd.res_ld  = 1'b1;
							cmd.res_sel = krt_pkg::RES_MISS;
							cmd.finish  = 1'b1;
							state_d     = krt_pkg::S_IDLE;
						end else begin
							state_d = krt_pkg::S_SEARCH;
						end
					end
					default: begin
						if (sts.slot_ok) begin
							cmd.read_slot = 1'b1;
							state_d       = krt_pkg::S_READ;
						end else begin
							cmd.res_ld  = 1'b1;
							cmd.res_sel = krt_pkg::RES_RANGE;
							cmd.finish  = 1'b1;
							state_d     = krt_pkg::S_IDLE;
						end
					end
				endcase
			end
			krt_pkg::S_SEARCH: begin
				if (sts.hit) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = krt_pkg::RES_HIT;
					if (sts.act == krt_pkg::ACT_REMOVE) begin
						cmd.shift_init = 1'b1;
						state_d        = krt_pkg::S_SHIFT;
					end else begin
						cmd.finish = 1'b1;
						state_d    = krt_pkg::S_IDLE;
					end
				end else if (sts.last_miss) begin
					cmd.res_ld = 1'b1;
					cmd.finish = 1'b1;
					state_d    = krt_pkg::S_IDLE;
					if (sts.act == krt_pkg::ACT_ADD) begin
						cmd.append  = 1'b1;
						cmd.res_sel = krt_pkg::RES_ADD;
					end else begin
						cmd.res_sel = krt_pkg::RES_MISS;
					end
				end else begin
					cmd.srch_step = 1'b1;
				end
			end
			krt_pkg::S_READ: begin
				cmd.res_ld  = 1'b1;
				cmd.res_sel = krt_pkg::RES_READ;
				cmd.finish  = 1'b1;
				state_d     = krt_pkg::S_IDLE;
			end
			krt_pkg::S_SHIFT: begin
				if (sts.shift_done) begin
					cmd.dec    = 1'b1;
					cmd.finish = 1'b1;
					state_d    = krt_pkg::S_IDLE;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			default: begin
				state_d = krt_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/krt_datapath.sv */
`timescale 1ns / 1ps

module krt_datapath #(
	parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  krt_pkg::krt_cmd_t           cmd,
	output krt_pkg::krt_sts_t           sts,
	input  logic [krt_pkg::ACT_W-1:0]   action,
	input  logic [krt_pkg::KEY_W-1:0]   key,
	input  logic [krt_pkg::PAY_W-1:0]   payload,
	input  logic [krt_pkg::SLOT_W-1:0]  slot,
	output logic                        done,
	output logic [krt_pkg::STAT_W-1:0]  status,
	output logic [krt_pkg::SLOT_W-1:0]  found_slot,
	output logic [krt_pkg::KEY_W-1:0]   record_key,
	output logic [krt_pkg::PAY_W-1:0]   record_payload,
	output logic [krt_pkg::CMP_W-1:0]   comparisons,
	output logic [krt_pkg::OCC_W-1:0]   occupancy
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (CW > krt_pkg::SLOT_W) ? CW : krt_pkg::SLOT_W;

	logic [krt_pkg::KEY_W-1:0] key_mem [CAPACITY];
	logic [krt_pkg::PAY_W-1:0] pay_mem [CAPACITY];

	krt_pkg::krt_action_t       action_q;
	logic [krt_pkg::KEY_W-1:0]  key_in_q;
	logic [krt_pkg::PAY_W-1:0]  pay_in_q;
	logic [krt_pkg::SLOT_W-1:0] slot_q;

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             rd_ptr_q;
	logic                      cmp_vld_q;
	logic [AW-1:0]             cmp_slot_q;
	logic [CW-1:0]             src_q;
	logic                      sh_vld_q;
	logic [AW-1:0]             sh_dst_s1;
	logic [krt_pkg::KEY_W-1:0] rd_key_q;
	logic [krt_pkg::PAY_W-1:0] rd_pay_q;

	krt_pkg::krt_status_t       status_q;
	logic [krt_pkg::SLOT_W-1:0] fslot_q;
	logic [krt_pkg::KEY_W-1:0]  rkey_q;
	logic [krt_pkg::PAY_W-1:0]  rpay_q;
	logic [krt_pkg::CMP_W-1:0]  cmps_q;
	logic                       done_q;

	logic                      mem_re, mem_we;
	logic [AW-1:0]             mem_ra, mem_wa;
	logic [krt_pkg::KEY_W-1:0] mem_wk;
	logic [krt_pkg::PAY_W-1:0] mem_wp;
	logic                      match, src_lt;
	logic [CW-1:0]             hit_cnt;

	assign match   = (rd_key_q == key_in_q);
	assign hit_cnt = CW'(cmp_slot_q) + CW'(1);
	assign src_lt  = (src_q < count_q);

	assign sts.act        = action_q;
	assign sts.full       = (count_q == CW'(CAPACITY));
	assign sts.empty      = (count_q == '0);
	assign sts.hit        = cmp_vld_q && match;
	assign sts.last_miss  = cmp_vld_q && !match && (hit_cnt == count_q);
	assign sts.slot_ok    = (SW'(slot_q) < SW'(count_q));
	assign sts.shift_done = !src_lt && !sh_vld_q;

	// single read and single write port; commands never collide
	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wk = key_in_q;
		mem_wp = pay_in_q;
		if (cmd.read_slot) begin
			mem_re = 1'b1;
			mem_ra = AW'(slot_q);
		end
		if (cmd.srch_step) begin
			mem_re = 1'b1;
			mem_ra = AW'(rd_ptr_q);
		end
		if (cmd.shift_step && src_lt) begin
			mem_re = 1'b1;
			mem_ra = AW'(src_q);
		end
		if (cmd.append) begin
			mem_we = 1'b1;
			mem_wa = AW'(count_q);
		end
		if (cmd.shift_step && sh_vld_q) begin
			mem_we = 1'b1;
			mem_wa = sh_dst_s1;
			mem_wk = rd_key_q;
			mem_wp = rd_pay_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_wa] <= mem_wk;
			pay_mem[mem_wa] <= mem_wp;
		end
		if (mem_re) begin
			rd_key_q <= key_mem[mem_ra];
			rd_pay_q <= pay_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_ptr_q  <= '0;
			cmp_vld_q <= 1'b0;
			src_q     <= '0;
			sh_vld_q  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.capture) begin
				rd_ptr_q  <= '0;
				cmp_vld_q <= 1'b0;
			end
			if (cmd.srch_step) begin
				rd_ptr_q  <= rd_ptr_q + CW'(1);
				cmp_vld_q <= 1'b1;
			end
			if (cmd.shift_init) begin
				src_q    <= hit_cnt;
				sh_vld_q <= 1'b0;
			end
			if (cmd.shift_step) begin
				if (src_lt) begin
					src_q    <= src_q + CW'(1);
					sh_vld_q <= 1'b1;
				end else begin
					sh_vld_q <= 1'b0;
				end
			end
			if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= krt_pkg::krt_action_t'(action);
			key_in_q <= key;
			pay_in_q <= payload;
			slot_q   <= slot;
		end
		if (cmd.srch_step) begin
			cmp_slot_q <= AW'(rd_ptr_q);
		end
		if (cmd.shift_step && src_lt) begin
			sh_dst_s1 <= AW'(src_q - CW'(1));
		end
		if (cmd.res_ld) begin
			unique case (cmd.res_sel)
				krt_pkg::RES_FULL: begin
					status_q <= krt_pkg::ST_FULL;
					fslot_q  <= '0;
					rkey_q   <= '0;
					rpay_q   <= '0;
					cmps_q   <= '0;
				end
				krt_pkg::RES_HIT: begin
					status_q <= (action_q == krt_pkg::ACT_ADD) ? krt_pkg::ST_DUP : krt_pkg::ST_OK;
					fslot_q  <= krt_pkg::SLOT_W'(cmp_slot_q);
					rkey_q   <= rd_key_q;
					rpay_q   <= rd_pay_q;
					cmps_q   <= (action_q == krt_pkg::ACT_FIND) ?
						krt_pkg::CMP_W'(hit_cnt) : '0;
				end
				krt_pkg::RES_MISS: begin
					status_q <= krt_pkg::ST_MISSING;
					fslot_q  <= '0;
					rkey_q   <= '0;
					rpay_q   <= '0;
					cmps_q   <= (action_q == krt_pkg::ACT_FIND) ?
						krt_pkg::CMP_W'(count_q) : '0;
				end
				krt_pkg::RES_ADD: begin
					status_q <= krt_pkg::ST_OK;
					fslot_q  <= krt_pkg::SLOT_W'(count_q);
					rkey_q   <= key_in_q;
					rpay_q   <= pay_in_q;
					cmps_q   <= '0;
				end
				krt_pkg::RES_RANGE: begin
					status_q <= krt_pkg::ST_RANGE;
					fslot_q  <= slot_q;
					rkey_q   <= '0;
					rpay_q   <= '0;
					cmps_q   <= '0;
				end
				krt_pkg::RES_READ: begin
					status_q <= krt_pkg::ST_OK;
					fslot_q  <= slot_q;
					rkey_q   <= rd_key_q;
					rpay_q   <= rd_pay_q;
					cmps_q   <= '0;
				end
				default: begin
					status_q <= krt_pkg::ST_OK;
					fslot_q  <= '0;
					rkey_q   <= '0;
					rpay_q   <= '0;
					cmps_q   <= '0;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found_slot     = fslot_q;
	assign record_key     = rkey_q;
	assign record_payload = rpay_q;
	assign comparisons    = cmps_q;
	// count settles on the same edge that raises done
	assign occupancy      = krt_pkg::OCC_W'(count_q);

endmodule

/* rtl/keyed_record_table.sv */
// One item at a time. A read goes through decode and one memory read to done; add, find and
// remove search from slot 0, one memory read per cycle, until a hit or the last record; remove
// then moves each later record down one slot. Full-table add, add to an empty table, empty
// find or remove and out-of-range read finish from decode without a search. Results come with
// done, which is high for one cycle and cannot be stalled; busy drops as done rises. Reset
// clears the record count; key and payload memories are left as is.
`timescale 1ns / 1ps

module keyed_record_table #(
	parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [krt_pkg::ACT_W-1:0]   action,
	input  logic [krt_pkg::KEY_W-1:0]   key,
	input  logic [krt_pkg::PAY_W-1:0]   payload,
	input  logic [krt_pkg::SLOT_W-1:0]  slot,
	output logic                        done,
	output logic [krt_pkg::STAT_W-1:0]  status,
	output logic [krt_pkg::SLOT_W-1:0]  found_slot,
	output logic [krt_pkg::KEY_W-1:0]   record_key,
	output logic [krt_pkg::PAY_W-1:0]   record_payload,
	output logic [krt_pkg::CMP_W-1:0]   comparisons,
	output logic [krt_pkg::OCC_W-1:0]   occupancy
);

`include "keyed_record_table_assert.svh"

	// Controller sequences the search, read and shift; datapath holds the tables.
	krt_pkg::krt_cmd_t cmd;
	krt_pkg::krt_sts_t sts;

	krt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	krt_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.key            (key),
		.payload        (payload),
		.slot           (slot),
		.done           (done),
		.status         (status),
		.found_slot     (found_slot),
		.record_key     (record_key),
		.record_payload (record_payload),
		.comparisons    (comparisons),
		.occupancy      (occupancy)
	);

	// An accepted item makes the block busy on the next cycle.
	`KRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// Never append into a full table.
	`KRT_ASSERT_NOW(a_append_room, cmd.append, !sts.full)
	// A result is shown only once the controller is back to idle.
	`KRT_ASSERT_NOW(a_done_idle, done, !busy)

endmodule
